[design/uvss_pkg.sv]
// shared types and codes for the unique value set store
package uvss_pkg;

   // default configuration
   localparam int CAPACITY_DEF   = 16;
   localparam int ELEM_WIDTH_DEF = 32;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // status codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_ERASED    = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_CLEARED   = 3'd5;

   // request payload
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] value;
   } req_type;

   // response payload
   typedef struct packed {
      logic [2:0] status;
      logic [4:0] count;
      logic       is_empty;
   } rsp_type;

endpackage

[design/uvss_mem.sv]
// entry storage: one write port, one read port with registered read data
module uvss_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/unique_value_set_store_core.sv]
// set of distinct values held in a compact memory array, top level
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_data  (op, value)
//  rsp      out        rsp_valid/rsp_stall   rsp_data  (status, count, is_empty)
//
// one request at a time: the search reads one entry per cycle through the
// memory read port, an erase then moves each later entry down one place per
// cycle through the same read port and the write port, continuing the sweep.
// a duplicate insert ends the search at the matching entry; clear and the unused
// code go straight to the response without a search.
// reset only clears the fill count and control, the memory needs no clearing.
// a stalled response is held in the output register while the next request runs.
module unique_value_set_store_core
   import uvss_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_SHIFT  = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic [CNT_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                  chk_ff, chk_in;
   logic [1:0]            op_ff, op_in;
   logic [ELEM_WIDTH-1:0] val_ff, val_in;
   logic [2:0]            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  rd_en;
   logic [ELEM_WIDTH-1:0] rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;
   logic                  issuing;
   logic                  match;
   logic [CNT_W-1:0]      shift_dst;
   logic [ELEM_WIDTH+31:0] val_ext;
   logic [CNT_W+4:0]      used_ext;

   // value compared over its low element bits
   assign val_ext = {{ELEM_WIDTH{1'b0}}, req_data.value};
   assign used_ext = {5'd0, used_ff};

   // read pipeline: issue counter runs one ahead of the compared entry
   assign issuing   = (issue_ff < used_ff) &&
                      ((state_ff == S_SEARCH) || (state_ff == S_SHIFT));
   assign rd_en     = issuing;
   assign match     = chk_ff && (rd_data == val_ff);
   assign shift_dst = chk_idx_ff - CNT_W'(1);

   uvss_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (ELEM_WIDTH),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      issue_in     = issue_ff;
      chk_idx_in   = chk_idx_ff;
      chk_in       = 1'b0;
      op_in        = op_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = used_ff[IDX_W-1:0];
      wr_data      = val_ff;

      if (issuing) begin
         issue_in   = issue_ff + CNT_W'(1);
         chk_in     = 1'b1;
         chk_idx_in = issue_ff;
      end

      case (state_ff)
         S_IDLE: begin
            issue_in = '0;
            chk_in   = 1'b0;
            if (req_valid) begin
               op_in  = req_data.op;
               val_in = val_ext[ELEM_WIDTH-1:0];
               case (req_data.op)
                  OP_INSERT, OP_ERASE: begin
                     state_in = S_SEARCH;
                  end
                  OP_CLEAR: begin
                     used_in   = '0;
                     status_in = ST_CLEARED;
                     state_in  = S_DONE;
                  end
                  default: begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         // linear search over the valid entries
         S_SEARCH: begin
            if (match) begin
               if (op_ff == OP_INSERT) begin
                  status_in = ST_DUPLICATE;
                  state_in  = S_DONE;
                  chk_in    = 1'b0;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (!issuing && !chk_ff) begin
               chk_in   = 1'b0;
               state_in = S_DONE;
               if (op_ff == OP_INSERT) begin
                  if (used_ff >= CNT_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     used_in   = used_ff + CNT_W'(1);
                     status_in = ST_INSERTED;
                  end
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
         end

         // move later entries down one place
         S_SHIFT: begin
            if (chk_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_dst[IDX_W-1:0];
               wr_data = rd_data;
            end else if (!issuing) begin
               used_in   = used_ff - CNT_W'(1);
               status_in = ST_ERASED;
               state_in  = S_DONE;
            end
         end

         // hand result to the output register
         S_DONE: begin
            chk_in = 1'b0;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.status   = status_ff;
               rsp_data_in.count    = used_ext[4:0];
               rsp_data_in.is_empty = (used_ff == '0);
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
            chk_in   = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      chk_idx_ff  <= chk_idx_in;
      op_ff       <= op_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[tb/unique_value_set_store_core_test.sv]
// self-checking testbench for the unique value set store core
module unique_value_set_store_core_test
   import uvss_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SET_CAPACITY   = CAPACITY_DEF;
   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam int          POOL_SIZE      = 20;
   localparam int          ITEMS_PER_PASS = 350;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          TAIL_CYCLES    = 50;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // requests waiting to be driven and responses waiting to arrive
   req_type     pending_reqs[$];
   rsp_type     expected_rsps[$];

   // shadow copy of the stored set
   logic [31:0] set_entries[SET_CAPACITY];
   int          set_used = 0;

   // pool of values so that duplicates and erase hits are frequent
   logic [31:0] value_pool[POOL_SIZE];

   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   logic        req_taken     = 1'b0;
   int          idle_cycles   = 0;
   int          error_count   = 0;
   int          req_count     = 0;
   int          rsp_count     = 0;
   int          status_seen[8];

   unique_value_set_store_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // apply one request to the shadow set and return the response it should give
   function automatic rsp_type apply_set_op(req_type r);
      int      pos;
      rsp_type res;
      pos = -1;
      for (int i = 0; i < set_used; i++) begin
         if (pos < 0 && set_entries[i] == r.value) pos = i;
      end
      case (r.op)
         OP_INSERT: begin
            if (pos >= 0) begin
               res.status = ST_DUPLICATE;
            end else if (set_used >= SET_CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               set_entries[set_used] = r.value;
               set_used++;
               res.status = ST_INSERTED;
            end
         end
         OP_ERASE: begin
            if (pos < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               // later entries move down one place
               for (int i = pos; i < set_used - 1; i++) set_entries[i] = set_entries[i + 1];
               set_used--;
               res.status = ST_ERASED;
            end
         end
         OP_CLEAR: begin
            set_used   = 0;
            res.status = ST_CLEARED;
         end
         default: begin
            res.status = ST_NOT_FOUND;
         end
      endcase
      res.count    = set_used[4:0];
      res.is_empty = (set_used == 0);
      return res;
   endfunction

   // random request biased toward inserts or erases
   function automatic req_type random_req(int insert_pct);
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 2) begin
         r.op = OP_UNUSED;
      end else if (pick < 5) begin
         r.op = OP_CLEAR;
      end else if (pick < 5 + insert_pct) begin
         r.op = OP_INSERT;
      end else begin
         r.op = OP_ERASE;
      end
      if ($urandom_range(9) == 0) begin
         r.value = $urandom;
      end else begin
         r.value = value_pool[$urandom_range(POOL_SIZE - 1)];
      end
      return r;
   endfunction

   task automatic queue_req(logic [1:0] op, logic [31:0] value);
      req_type r;
      r.op    = op;
      r.value = value;
      pending_reqs.push_back(r);
   endtask

   task automatic note_failure(string msg);
      error_count++;
      if (error_count <= 10) $display("%t  %s", $realtime, msg);
   endtask

   // hold off until every request is out and every response is back
   task automatic wait_for_drain();
      do
         @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   // request driver and response stall, updated on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         set_used  = 0;
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            req_count++;
            expected_rsps.push_back(apply_set_op(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            status_seen[rsp_data.status]++;
            if (expected_rsps.size() == 0) begin
               note_failure($sformatf("unexpected response status %0d count %0d empty %0b",
                                      rsp_data.status, rsp_data.count, rsp_data.is_empty));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status || rsp_data.count !== want.count ||
                   rsp_data.is_empty !== want.is_empty) begin
                  note_failure($sformatf(
                     "mismatch: expected status %0d count %0d empty %0b, got %0d %0d %0b",
                     want.status, want.count, want.is_empty,
                     rsp_data.status, rsp_data.count, rsp_data.is_empty));
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a handshake", idle_cycles);
         $display("unique_value_set_store_core_test: done, errors");
         $finish;
      end
   end

   // stimulus
   initial begin
      int mix;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, duplicate, miss, last slot, unused code, full set, clear
      queue_req(OP_INSERT, 32'h0000_0000);
      queue_req(OP_INSERT, 32'hFFFF_FFFF);
      queue_req(OP_INSERT, 32'h0000_0000);
      queue_req(OP_ERASE,  32'h0000_0005);
      queue_req(OP_ERASE,  32'hFFFF_FFFF);
      queue_req(OP_UNUSED, $urandom);
      for (int i = 1; i < SET_CAPACITY; i++) queue_req(OP_INSERT, 32'h0101_0101 * i);
      queue_req(OP_INSERT, 32'hA5A5_A5A5);
      queue_req(OP_INSERT, 32'h0000_0000);
      queue_req(OP_ERASE,  32'h0000_0000);
      queue_req(OP_CLEAR,  $urandom);
      wait_for_drain();

      // random passes with different idle and stall mixes
      for (int pass = 0; pass < 4; pass++) begin
         case (pass)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 58; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 58; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         value_pool[0] = 32'h0000_0000;
         value_pool[1] = 32'hFFFF_FFFF;
         for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom;
         mix = 50;
         for (int n = 0; n < ITEMS_PER_PASS; n++) begin
            // segments that fill the set, drain it, or churn
            if (n % 40 == 0) begin
               case ($urandom_range(2))
                  0: mix = 85;
                  1: mix = 50;
                  default: mix = 25;
               endcase
            end
            pending_reqs.push_back(random_req(mix));
         end
         wait_for_drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         note_failure($sformatf("%0d responses never arrived", expected_rsps.size()));
      end

      $display("%0d requests, %0d responses over four idle/stall mixes", req_count, rsp_count);
      $display("inserted %0d, duplicate %0d, full %0d, erased %0d, not found %0d, cleared %0d",
               status_seen[ST_INSERTED], status_seen[ST_DUPLICATE], status_seen[ST_FULL],
               status_seen[ST_ERASED], status_seen[ST_NOT_FOUND], status_seen[ST_CLEARED]);
      if (error_count == 0) begin
         $display("unique_value_set_store_core_test: done, clean");
      end else begin
         $display("unique_value_set_store_core_test: done, errors");
      end
      $finish;
   end

endmodule

[sim.f]
design/uvss_pkg.sv
design/uvss_mem.sv
design/unique_value_set_store_core.sv
tb/unique_value_set_store_core_test.sv
